/* sv/vpt_pkg.sv */
`default_nettype none
package vpt_pkg;

  // Field and register widths
  localparam int COORD_W  = 16;
  localparam int ENTRY_W  = 16;
  localparam int ROW_W    = 64;
  localparam int NUM_ROWS = 4;
  localparam int NUM_COLS = 4;
  localparam int LANES    = 3;

  // Quotient bits kept by the divider: 16 result bits plus an overflow bit
  localparam int QUO_W = COORD_W + 1;

  // APB register file
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_ONE   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW_TWO   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROW_THREE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROW_FOUR  = 3'd4;

  localparam logic MODE_LINEAR     = 1'b0;
  localparam logic MODE_PROJECTIVE = 1'b1;
  localparam logic MODE_RESET      = MODE_PROJECTIVE;

  // Identity matrix, Q4.12
  localparam logic [NUM_ROWS-1:0][ROW_W-1:0] ROW_RESET = '{
    64'h1000_0000_0000_0000,
    64'h0000_1000_0000_0000,
    64'h0000_0000_1000_0000,
    64'h0000_0000_0000_1000
  };

  // Saturation limits
  localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
  localparam logic [QUO_W-1:0] POS_LIMIT = 17'd32767;
  localparam logic [QUO_W-1:0] NEG_LIMIT = 17'd32768;

  typedef struct packed {
    logic                              mode;
    logic [NUM_ROWS-1:0][ROW_W-1:0]    rows;
  } vpt_cfg_t;

endpackage
`default_nettype wire

/* sv/vpt_if.sv */
`default_nettype none
interface vpt_point_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [vpt_pkg::COORD_W-1:0]    point_x;
  logic signed [vpt_pkg::COORD_W-1:0]    point_y;
  logic signed [vpt_pkg::COORD_W-1:0]    point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface vpt_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [vpt_pkg::COORD_W-1:0]    out_x;
  logic signed [vpt_pkg::COORD_W-1:0]    out_y;
  logic signed [vpt_pkg::COORD_W-1:0]    out_z;
  logic                                  w_zero;
  logic                                  clipped;

  modport source (output valid, out_x, out_y, out_z, w_zero, clipped, input ready);
  modport sink   (input valid, out_x, out_y, out_z, w_zero, clipped, output ready);
endinterface
`default_nettype wire

/* sv/vertex_projective_transform_core.sv */
`default_nettype none
// Transforms one signed fixed-point 3D point per request as a row vector by a
// 4x4 matrix held in APB registers. Mode 0 applies the 3x3 part; mode 1 adds
// the translation row, forms w and divides x, y, z by it. Results are rounded
// to nearest (ties away from zero), saturated to 16 bits and flagged. The
// pipeline accepts one request per clock while it is not stalled; its stages
// are multiply, sum, operand setup, 17 restoring-divider stages (one quotient
// bit each, three lanes in parallel) and the output register. A stalled output
// only stops the stages behind it once they are full.
module vertex_projective_transform_core #(
  parameter int COORD_FRAC_BITS  = 8,
  parameter int MATRIX_FRAC_BITS = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [vpt_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [vpt_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [vpt_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  vpt_point_if.sink                              points,
  vpt_result_if.source                           results
);

  localparam int CW     = vpt_pkg::COORD_W;
  localparam int EW     = vpt_pkg::ENTRY_W;
  localparam int LN     = vpt_pkg::LANES;
  localparam int QW     = vpt_pkg::QUO_W;
  localparam int PROD_W = CW + EW;
  localparam int ACC_W  = PROD_W + 2;
  localparam int NUM_W  = ACC_W + COORD_FRAC_BITS;
  localparam int N_W    = NUM_W + 2;
  localparam int D_W    = ACC_W + 2;
  localparam int NS     = QW + 4;

  vpt_pkg::vpt_cfg_t cfg;

  vpt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Matrix entries
  logic signed [EW-1:0] ent [vpt_pkg::NUM_ROWS][vpt_pkg::NUM_COLS];
  always_comb begin
    for (int r = 0; r < vpt_pkg::NUM_ROWS; r++) begin
      for (int c = 0; c < vpt_pkg::NUM_COLS; c++) begin
        ent[r][c] = cfg.rows[r][EW*c +: EW];
      end
    end
  end

  // Stage valids and advance chain
  logic [NS-1:0] v;
  logic [NS:0]   adv;

  always_comb begin
    adv[NS] = results.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign points.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= points.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage 1: products
  logic signed [CW-1:0]     pin [LN];
  logic signed [PROD_W-1:0] prod [LN][vpt_pkg::NUM_COLS];

  assign pin[0] = points.point_x;
  assign pin[1] = points.point_y;
  assign pin[2] = points.point_z;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int r = 0; r < LN; r++) begin
        for (int c = 0; c < vpt_pkg::NUM_COLS; c++) begin
          prod[r][c] <= pin[r] * ent[r][c];
        end
      end
    end
  end

  // Stage 2: column sums, translation and w
  logic signed [ACC_W-1:0] sum_c [vpt_pkg::NUM_COLS];
  logic signed [ACC_W-1:0] s2_sum [vpt_pkg::NUM_COLS];

  always_comb begin
    for (int c = 0; c < vpt_pkg::NUM_COLS; c++) begin
      sum_c[c] = ACC_W'(prod[0][c]) + ACC_W'(prod[1][c]) + ACC_W'(prod[2][c]);
      if (cfg.mode == vpt_pkg::MODE_PROJECTIVE || c == LN) begin
        sum_c[c] = sum_c[c] + (ACC_W'(ent[3][c]) <<< COORD_FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_sum <= sum_c;
    end
  end

  // Stage 3: magnitudes, rounding offset, sign; then divider stages
  logic [N_W-1:0] dv_r   [QW+1][LN];
  logic [QW-1:0]  dv_q   [QW+1][LN];
  logic [LN-1:0]  dv_neg [QW+1];
  logic [D_W-1:0] dv_d   [QW+1];
  logic           dv_wz  [QW+1];

  logic signed [NUM_W-1:0] num [LN];
  logic signed [ACC_W-1:0] den;
  logic [NUM_W-1:0]        an [LN];
  logic [ACC_W-1:0]        ad;
  logic [N_W-1:0]          n_init [LN];
  logic [LN-1:0]           neg_init;

  always_comb begin
    if (cfg.mode == vpt_pkg::MODE_PROJECTIVE) begin
      den = s2_sum[LN];
    end else begin
      den = ACC_W'(1) <<< MATRIX_FRAC_BITS;
    end
    ad = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
    for (int l = 0; l < LN; l++) begin
      if (cfg.mode == vpt_pkg::MODE_PROJECTIVE) begin
        num[l] = NUM_W'(s2_sum[l]) <<< COORD_FRAC_BITS;
      end else begin
        num[l] = NUM_W'(s2_sum[l]);
      end
      an[l]       = num[l][NUM_W-1] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
      n_init[l]   = (N_W'(an[l]) << 1) + N_W'(ad);
      neg_init[l] = num[l][NUM_W-1] ^ den[ACC_W-1];
    end
  end

  wire [N_W-1:0] step_rem [QW+1][LN];
  wire           step_bit [QW+1][LN];

  for (genvar j = 1; j <= QW; j++) begin : g_stage
    for (genvar l = 0; l < LN; l++) begin : g_lane
      vpt_div_step #(
        .REM_W (N_W),
        .DEN_W (D_W),
        .SHIFT (QW - j)
      ) u_step (
        .rem      (dv_r[j-1][l]),
        .den      (dv_d[j-1]),
        .rem_next (step_rem[j][l]),
        .quo_bit  (step_bit[j][l])
      );
    end
  end

  for (genvar l = 0; l < LN; l++) begin : g_unused
    assign step_rem[0][l] = '0;
    assign step_bit[0][l] = 1'b0;
  end

  always_ff @(posedge clk) begin
    // Load operands
    if (adv[2]) begin
      for (int l = 0; l < LN; l++) begin
        dv_r[0][l] <= n_init[l];
        dv_q[0][l] <= '0;
      end
      dv_neg[0] <= neg_init;
      dv_d[0]   <= D_W'(ad) << 1;
      dv_wz[0]  <= (cfg.mode == vpt_pkg::MODE_PROJECTIVE) && (s2_sum[LN] == '0);
    end
    // Advance one quotient bit per stage, MSB first
    for (int j = 1; j <= QW; j++) begin
      if (adv[2+j]) begin
        for (int l = 0; l < LN; l++) begin
          dv_r[j][l] <= step_rem[j][l] | (step_rem[0][l] & '0);
          dv_q[j][l] <= {dv_q[j-1][l][QW-2:0], step_bit[j][l] | step_bit[0][l]};
        end
        dv_neg[j] <= dv_neg[j-1];
        dv_d[j]   <= dv_d[j-1];
        dv_wz[j]  <= dv_wz[j-1];
      end
    end
  end

  // Output stage: sign, saturation, zero-w override
  logic signed [CW-1:0] res_c [LN];
  logic [LN-1:0]        clip_c;
  logic signed [CW-1:0] o_coord [LN];
  logic                 o_wz;
  logic                 o_clip;

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      if (dv_wz[QW]) begin
        clip_c[l] = 1'b0;
        res_c[l]  = '0;
      end else if (dv_neg[QW][l]) begin
        clip_c[l] = dv_q[QW][l] > vpt_pkg::NEG_LIMIT;
        res_c[l]  = clip_c[l] ? vpt_pkg::COORD_MIN : CW'(-dv_q[QW][l]);
      end else begin
        clip_c[l] = dv_q[QW][l] > vpt_pkg::POS_LIMIT;
        res_c[l]  = clip_c[l] ? vpt_pkg::COORD_MAX : CW'(dv_q[QW][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      o_coord <= res_c;
      o_wz    <= dv_wz[QW];
      o_clip  <= |clip_c;
    end
  end

  assign results.valid   = v[NS-1];
  assign results.out_x   = o_coord[0];
  assign results.out_y   = o_coord[1];
  assign results.out_z   = o_coord[2];
  assign results.w_zero  = o_wz;
  assign results.clipped = o_clip;

`ifndef SYNTHESIS
  // Zero w forces zero coordinates and no clip
  a_wzero_outputs: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.w_zero |->
      results.out_x == '0 && results.out_y == '0 && results.out_z == '0 &&
      !results.clipped)
    else $error("zero-w result carries nonzero data");

  // Linear mode never reports zero w
  a_linear_no_wzero: assert property (@(posedge clk) disable iff (rst)
    results.valid && cfg.mode == vpt_pkg::MODE_LINEAR |-> !results.w_zero)
    else $error("w_zero set in linear mode");

  // An empty output register lets the whole pipe move
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !results.valid |-> points.ready)
    else $error("input stalled with empty output stage");
`endif

endmodule
`default_nettype wire

/* sv/vpt_cfg.sv */
`default_nettype none
module vpt_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [vpt_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [vpt_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [vpt_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  output vpt_pkg::vpt_cfg_t                      cfg
);

  logic [vpt_pkg::REG_IDX_W-1:0] idx;
  logic                          wr_en;

  assign idx    = paddr[vpt_pkg::APB_ADDR_W-1:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= vpt_pkg::MODE_RESET;
      cfg.rows <= vpt_pkg::ROW_RESET;
    end else if (wr_en) begin
      case (idx)
        vpt_pkg::REG_MODE:      cfg.mode    <= pwdata[0];
        vpt_pkg::REG_ROW_ONE:   cfg.rows[0] <= pwdata;
        vpt_pkg::REG_ROW_TWO:   cfg.rows[1] <= pwdata;
        vpt_pkg::REG_ROW_THREE: cfg.rows[2] <= pwdata;
        vpt_pkg::REG_ROW_FOUR:  cfg.rows[3] <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      vpt_pkg::REG_MODE:      prdata = vpt_pkg::APB_DATA_W'(cfg.mode);
      vpt_pkg::REG_ROW_ONE:   prdata = cfg.rows[0];
      vpt_pkg::REG_ROW_TWO:   prdata = cfg.rows[1];
      vpt_pkg::REG_ROW_THREE: prdata = cfg.rows[2];
      vpt_pkg::REG_ROW_FOUR:  prdata = cfg.rows[3];
      default:                prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* sv/vpt_div_step.sv */
`default_nettype none
// One restoring-division step: subtract the shifted divisor when it fits.
module vpt_div_step #(
  parameter int REM_W = 44,
  parameter int DEN_W = 36,
  parameter int SHIFT = 0
) (
  input  wire logic [REM_W-1:0] rem,
  input  wire logic [DEN_W-1:0] den,
  output logic      [REM_W-1:0] rem_next,
  output logic                  quo_bit
);

  localparam int CMP_W = ((REM_W > DEN_W + SHIFT) ? REM_W : DEN_W + SHIFT) + 1;

  logic [CMP_W-1:0] rem_ext;
  logic [CMP_W-1:0] den_ext;
  logic [CMP_W-1:0] diff;

  always_comb begin
    rem_ext  = CMP_W'(rem);
    den_ext  = CMP_W'(den) << SHIFT;
    diff     = rem_ext - den_ext;
    quo_bit  = (rem_ext >= den_ext);
    rem_next = quo_bit ? diff[REM_W-1:0] : rem;
  end

endmodule
`default_nettype wire
